// File: design/sorted_pair_composition_search_defines.svh
// Assertion helpers for the file that checks this block.
`ifndef SORTED_PAIR_COMPOSITION_SEARCH_DEFINES_SVH
`define SORTED_PAIR_COMPOSITION_SEARCH_DEFINES_SVH

// Checked at every rising clock edge while reset is released.
`define SPCS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define SPCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/spcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spcs_pkg;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned FIELD_W     = 21;
  localparam int unsigned ADDR_W      = 12;
  localparam int unsigned START_W     = 13;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  // Walk pointer: holds any start value minus one and the depth plus one.
  localparam int unsigned PTR_W       = ($clog2(TABLE_DEPTH + 2) > START_W) ?
                                        $clog2(TABLE_DEPTH + 2) : START_W;

  localparam logic [FIELD_W-1:0] NOT_FOUND = FIELD_W'(16'hFFFF);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WAIT0 = 4'b0010,
    S_WAIT1 = 4'b0100,
    S_FIN   = 4'b1000
  } spcs_state_e;

  typedef struct packed {
    logic [FIELD_W-1:0] result_cp;
    logic               found;
    logic               range_error;
  } res_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [IDX_W-1:0]  addr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

endpackage

`default_nettype wire

// File: design/spcs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Single-port synchronous RAM with a registered read port.
module spcs_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/spcs_walker.sv
`timescale 1ns / 1ps
`default_nettype none

// Request sequencer: performs loads and walks the sorted pair list of a lookup.
module spcs_walker import spcs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               req_type_i,
  input  wire logic [ADDR_W-1:0]  load_address_i,
  input  wire logic [WORD_W-1:0]  load_word_i,
  input  wire logic [START_W-1:0] start_position_i,
  input  wire logic [FIELD_W-1:0] second_code_point_i,
  input  wire logic               out_free_i,
  output logic                    res_valid_o,
  output res_t                    res_o,
  output mem_req_t                mem_o,
  input  wire logic [WORD_W-1:0]  rdata_i
);

  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(TABLE_DEPTH);

  spcs_state_e        state_q, state_d;
  logic [PTR_W-1:0]   idx_q, idx_d;
  logic [FIELD_W-1:0] probe_q, probe_d;
  logic               k1_eq_q, k1_eq_d;
  res_t               res_q, res_d;

  logic [PTR_W-1:0]   start_idx;
  logic [PTR_W-1:0]   load_ptr;
  logic [PTR_W-1:0]   idx_inc;
  logic [FIELD_W-1:0] key0, key1, key2;
  logic               accept;

  assign start_idx = PTR_W'(start_position_i) - PTR_W'(1);
  assign load_ptr  = PTR_W'(load_address_i);
  assign idx_inc   = idx_q + PTR_W'(1);
  assign key0      = rdata_i[FIELD_W-1:0];
  assign key1      = rdata_i[3*FIELD_W-1:2*FIELD_W];
  assign key2      = rdata_i[2*FIELD_W-1:FIELD_W];
  assign accept    = in_valid_i && !in_stall_o;

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_FIN) && out_free_i;
  assign res_o       = res_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    probe_d = probe_q;
    k1_eq_d = k1_eq_q;
    res_d   = res_q;
    mem_o   = '{we: 1'b0, re: 1'b0, addr: '0, wdata: load_word_i};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!req_type_i) begin
            mem_o.we   = (load_ptr < DEPTH_P);
            mem_o.addr = load_ptr[IDX_W-1:0];
          end else begin
            probe_d = second_code_point_i;
            idx_d   = start_idx;
            if (start_position_i == '0) begin
              res_d   = '{result_cp: NOT_FOUND, found: 1'b0, range_error: 1'b0};
              state_d = S_FIN;
            end else if (start_idx >= DEPTH_P) begin
              res_d   = '{result_cp: NOT_FOUND, found: 1'b0, range_error: 1'b1};
              state_d = S_FIN;
            end else begin
              mem_o.re   = 1'b1;
              mem_o.addr = start_idx[IDX_W-1:0];
              state_d    = S_WAIT0;
            end
          end
        end
      end
      S_WAIT0: begin
        state_d = S_FIN;
        if (key0 > probe_q) begin
          res_d = '{result_cp: NOT_FOUND, found: 1'b0, range_error: 1'b0};
        end else if (key0 == probe_q) begin
          res_d = '{result_cp: rdata_i[2*FIELD_W-1:FIELD_W], found: 1'b1,
                    range_error: 1'b0};
        end else if (key1 > probe_q) begin
          res_d = '{result_cp: NOT_FOUND, found: 1'b0, range_error: 1'b0};
        end else if (idx_inc >= DEPTH_P) begin
          res_d = '{result_cp: NOT_FOUND, found: 1'b0, range_error: 1'b1};
        end else begin
          k1_eq_d    = (key1 == probe_q);
          idx_d      = idx_inc;
          mem_o.re   = 1'b1;
          mem_o.addr = idx_inc[IDX_W-1:0];
          state_d    = S_WAIT1;
        end
      end
      S_WAIT1: begin
        state_d = S_FIN;
        if (k1_eq_q) begin
          res_d = '{result_cp: rdata_i[FIELD_W-1:0], found: 1'b1, range_error: 1'b0};
        end else if (key2 > probe_q) begin
          res_d = '{result_cp: NOT_FOUND, found: 1'b0, range_error: 1'b0};
        end else if (key2 == probe_q) begin
          res_d = '{result_cp: rdata_i[3*FIELD_W-1:2*FIELD_W], found: 1'b1,
                    range_error: 1'b0};
        end else if (rdata_i[WORD_W-1]) begin
          res_d = '{result_cp: NOT_FOUND, found: 1'b0, range_error: 1'b0};
        end else if (idx_inc >= DEPTH_P) begin
          res_d = '{result_cp: NOT_FOUND, found: 1'b0, range_error: 1'b1};
        end else begin
          idx_d      = idx_inc;
          mem_o.re   = 1'b1;
          mem_o.addr = idx_inc[IDX_W-1:0];
          state_d    = S_WAIT0;
        end
      end
      S_FIN: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    probe_q <= probe_d;
    k1_eq_q <= k1_eq_d;
    res_q   <= res_d;
  end

endmodule

`default_nettype wire

// File: design/sorted_pair_composition_search.sv
// Sorted pair composition search. The block keeps a table of 4096 64-bit
// words in a single-port synchronous RAM. A load request (req_type 0) writes
// load_word at load_address and produces no result. A lookup
// request (req_type 1) walks a sorted list of packed (key, result) pairs that
// begins at table word start_position - 1 and produces exactly one result:
// the paired code point with found set on a key match, or 0xFFFF when a key
// exceeds the probe, when the list ends (bit 63 of the second word of a pair)
// or when start_position is zero. A walk that would read past the table end
// returns 0xFFFF with range_error set. Lookups are served one at a time: the
// RAM port delivers one word per read from its registered read port, so a
// lookup reads its table words one after another (two per word pair, one
// when it stops at the first word of a pair) before its result is handed to
// the output register; a lookup that needs no table read skips the walk.
// The sequencer takes the next request in the cycle after the handover,
// while a load never stalls it. The output register lets the next request
// enter while a finished result waits to be taken; only a second finished
// result stalls the sequencer.
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_pair_composition_search_defines.svh"

module sorted_pair_composition_search import spcs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               req_type_i,
  input  wire logic [ADDR_W-1:0]  load_address_i,
  input  wire logic [WORD_W-1:0]  load_word_i,
  input  wire logic [START_W-1:0] start_position_i,
  input  wire logic [FIELD_W-1:0] second_code_point_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [FIELD_W-1:0] composed_code_point_o,
  output logic                    found_o,
  output logic                    range_error_o
);

  mem_req_t          mem_req;
  logic [WORD_W-1:0] rdata;
  logic              res_valid;
  res_t              res;
  logic              out_free;
  logic              out_valid_q;
  res_t              out_q;

  // The output register can take a new result when it is empty or when its
  // current result leaves in this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  spcs_walker u_walker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .req_type_i          (req_type_i),
    .load_address_i      (load_address_i),
    .load_word_i         (load_word_i),
    .start_position_i    (start_position_i),
    .second_code_point_i (second_code_point_i),
    .out_free_i          (out_free),
    .res_valid_o         (res_valid),
    .res_o               (res),
    .mem_o               (mem_req),
    .rdata_i             (rdata)
  );

  spcs_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .re_i    (mem_req.re),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (rdata)
  );

  // Output register of the result channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign composed_code_point_o = out_q.result_cp;
  assign found_o               = out_q.found;
  assign range_error_o         = out_q.range_error;

  // A match and a range error never come together.
  `SPCS_ASSERT(a_found_no_error, clk_i, rst_ni,
               out_valid_o |-> !(found_o && range_error_o),
               "found and range_error both set")
  // Every miss carries the not-found code point.
  `SPCS_ASSERT(a_miss_code, clk_i, rst_ni,
               (out_valid_o && !found_o) |-> (composed_code_point_o == NOT_FOUND),
               "miss without the not-found code point")
  // An accepted lookup keeps the block busy in the following cycle.
  `SPCS_ASSERT(a_lookup_busy, clk_i, rst_ni,
               (in_valid_i && !in_stall_o && req_type_i) |=> in_stall_o,
               "lookup did not occupy the sequencer")
  // No result is offered while reset is held.
  `SPCS_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_o,
                      "result offered during reset")

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import spcs_pkg::*;

  // Request kinds carried on req_type.
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // Largest probe a lookup carries, and the largest value a packed field holds.
  localparam int CP_MAX  = 'h10FFFF;
  localparam int KEY_MAX = 'h1FFFFF;

  // Minimum number of requests in the random part, loads and filler loads included.
  localparam int RANDOM_ITEMS = 1450;

  // One request as the sender sees it. Rows with a typed expectation carry
  // their own result; every other lookup is scored against the predictor.
  typedef struct {
    logic                req_type;
    logic [ADDR_W-1:0]   addr;
    logic [WORD_W-1:0]   word;
    logic [START_W-1:0]  start;
    logic [FIELD_W-1:0]  probe;
    bit                  typed;
    res_t                want;
  } comp_req_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b1;

  logic               in_valid_r   = 1'b0;
  logic               req_type_r   = REQ_LOAD;
  logic [ADDR_W-1:0]  load_addr_r  = '0;
  logic [WORD_W-1:0]  load_word_r  = '0;
  logic [START_W-1:0] start_pos_r  = '0;
  logic [FIELD_W-1:0] probe_r      = '0;
  logic               out_stall_r  = 1'b0;

  logic               in_stall_o;
  logic               out_valid_o;
  logic [FIELD_W-1:0] composed_code_point_o;
  logic               found_o;
  logic               range_error_o;

  // Mirror of the block's table. A word counts as loaded only once a load
  // request for it has been accepted; lookups never touch anything else.
  logic [WORD_W-1:0] pair_words [TABLE_DEPTH];
  bit                word_loaded[TABLE_DEPTH];

  res_t pending_results[$];
  int   mismatches     = 0;
  int   requests_sent  = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;

  sorted_pair_composition_search DUT (
    .clk_i                 (clk_i),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid_r),
    .in_stall_o            (in_stall_o),
    .req_type_i            (req_type_r),
    .load_address_i        (load_addr_r),
    .load_word_i           (load_word_r),
    .start_position_i      (start_pos_r),
    .second_code_point_i   (probe_r),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_r),
    .composed_code_point_o (composed_code_point_o),
    .found_o               (found_o),
    .range_error_o         (range_error_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Walks the mirrored table the way the block does. Returns -1 when the
  // walk is complete and res holds the answer, or the index of the first
  // word the walk would read that has not been loaded yet.
  function automatic int compose_lookup(input logic [START_W-1:0] start,
                                        input logic [FIELD_W-1:0] probe,
                                        output res_t res);
    int                 idx;
    logic [WORD_W-1:0]  w0;
    logic [WORD_W-1:0]  w1;
    logic [FIELD_W-1:0] key;
    res = '{NOT_FOUND, 1'b0, 1'b0};
    if (start == '0) return -1;
    idx = int'(start) - 1;
    while (1'b1) begin
      if (idx >= int'(TABLE_DEPTH)) begin
        res.range_error = 1'b1;
        return -1;
      end
      if (!word_loaded[idx]) return idx;
      w0 = pair_words[idx];
      idx++;
      key = w0[20:0];
      if (key > probe) return -1;
      if (key == probe) begin
        res = '{w0[41:21], 1'b1, 1'b0};
        return -1;
      end
      // The second key's result lives in the next word, so that word must
      // exist even when this key already matches.
      key = w0[62:42];
      if (key > probe) return -1;
      if (idx >= int'(TABLE_DEPTH)) begin
        res.range_error = 1'b1;
        return -1;
      end
      if (!word_loaded[idx]) return idx;
      w1 = pair_words[idx];
      idx++;
      if (key == probe) begin
        res = '{w1[20:0], 1'b1, 1'b0};
        return -1;
      end
      key = w1[41:21];
      if (key > probe) return -1;
      if (key == probe) begin
        res = '{w1[62:42], 1'b1, 1'b0};
        return -1;
      end
      if (w1[63]) return -1;
    end
    return -1;
  endfunction

  // First word of a pair: key0, result0, key1 and an unused top bit.
  function automatic logic [WORD_W-1:0] pack_lo(input logic [FIELD_W-1:0] k0,
                                                input logic [FIELD_W-1:0] r0,
                                                input logic [FIELD_W-1:0] k1,
                                                input logic spare);
    return {spare, k1, r0, k0};
  endfunction

  // Second word of a pair: result1, key2, result2 and the end-of-list flag.
  function automatic logic [WORD_W-1:0] pack_hi(input logic [FIELD_W-1:0] r1,
                                                input logic [FIELD_W-1:0] k2,
                                                input logic [FIELD_W-1:0] r2,
                                                input logic last);
    return {last, r2, k2, r1};
  endfunction

  function automatic comp_req_t load_row(input logic [ADDR_W-1:0] addr,
                                         input logic [WORD_W-1:0] word);
    comp_req_t r;
    r.req_type = REQ_LOAD;
    r.addr     = addr;
    r.word     = word;
    r.start    = START_W'($urandom);
    r.probe    = FIELD_W'($urandom);
    r.typed    = 1'b0;
    r.want     = '0;
    return r;
  endfunction

  function automatic comp_req_t lookup_row(input logic [START_W-1:0] start,
                                           input logic [FIELD_W-1:0] probe);
    comp_req_t r;
    r.req_type = REQ_LOOKUP;
    r.addr     = ADDR_W'($urandom);
    r.word     = {$urandom, $urandom};
    r.start    = start;
    r.probe    = probe;
    r.typed    = 1'b0;
    r.want     = '0;
    return r;
  endfunction

  // Lookups whose answer is plain from the request alone: no list, a start
  // beyond the table, or a walk that runs off the end of the table.
  function automatic comp_req_t typed_row(input logic [START_W-1:0] start,
                                          input logic [FIELD_W-1:0] probe,
                                          input logic err);
    comp_req_t r;
    r       = lookup_row(start, probe);
    r.typed = 1'b1;
    r.want  = '{NOT_FOUND, 1'b0, err};
    return r;
  endfunction

  // Presents one request at a falling edge and holds it until it is taken.
  // The mirror and the expected results advance at the accepting edge.
  task automatic issue(input comp_req_t r);
    res_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_r <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_r  <= 1'b1;
    req_type_r  <= r.req_type;
    load_addr_r <= r.addr;
    load_word_r <= r.word;
    start_pos_r <= r.start;
    probe_r     <= r.probe;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (r.req_type == REQ_LOAD) begin
      pair_words[r.addr]  = r.word;
      word_loaded[r.addr] = 1'b1;
    end else begin
      void'(compose_lookup(r.start, r.probe, want));
      if (r.typed) want = r.want;
      pending_results.push_back(want);
    end
    requests_sent++;
    @(negedge clk_i);
  endtask

  // A lookup may only read words that were loaded, so any word its walk
  // would reach first gets a random value loaded ahead of it.
  task automatic send_request(input comp_req_t r);
    res_t scratch;
    int   miss;
    if (r.req_type == REQ_LOOKUP) begin
      miss = compose_lookup(r.start, r.probe, scratch);
      while (miss >= 0) begin
        issue(load_row(ADDR_W'(miss), {$urandom, $urandom}));
        miss = compose_lookup(r.start, r.probe, scratch);
      end
    end
    issue(r);
  endtask

  // Loads a well-formed sorted list with random content and then probes it.
  // Some lists sit against the end of the table, some of those without an
  // end marker, and a few carry an early end marker.
  task automatic run_list_episode();
    int                 pairs;
    int                 base;
    int                 span;
    int                 lo;
    int                 hi;
    int                 k;
    int                 start;
    int                 probe;
    int                 keys[$];
    logic [FIELD_W-1:0] outs[$];
    bit                 near_end;
    bit                 truncated;
    logic               last;
    pairs     = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    near_end  = ($urandom_range(6) == 0);
    truncated = near_end && ($urandom_range(1) == 1);
    if (near_end) base = TABLE_DEPTH - 2 * pairs + $urandom_range(1);
    else base = $urandom_range(TABLE_DEPTH - 2 * pairs);
    case ($urandom_range(2))
      0: span = 'h30;
      1: span = 'h1000;
      default: span = KEY_MAX;
    endcase
    case ($urandom_range(9))
      0: lo = 0;
      1: lo = $urandom_range(KEY_MAX);
      default: lo = $urandom_range(CP_MAX);
    endcase
    hi = (lo + span > KEY_MAX) ? KEY_MAX : lo + span;
    for (int i = 0; i < 3 * pairs; i++) begin
      keys.push_back($urandom_range(hi, lo));
      outs.push_back(FIELD_W'($urandom));
    end
    keys.sort();
    for (int p = 0; p < pairs; p++) begin
      if (p == pairs - 1) last = !truncated;
      else last = ($urandom_range(15) == 0);
      if (base + 2 * p < int'(TABLE_DEPTH))
        send_request(load_row(ADDR_W'(base + 2 * p),
                              pack_lo(FIELD_W'(keys[3*p]), outs[3*p],
                                      FIELD_W'(keys[3*p+1]), 1'($urandom))));
      if (base + 2 * p + 1 < int'(TABLE_DEPTH))
        send_request(load_row(ADDR_W'(base + 2 * p + 1),
                              pack_hi(outs[3*p+1], FIELD_W'(keys[3*p+2]),
                                      outs[3*p+2], last)));
    end
    repeat ($urandom_range(2, 6)) begin
      k = keys[$urandom_range(keys.size() - 1)];
      case ($urandom_range(9))
        6: probe = k + 1;
        7: probe = (k > 0) ? k - 1 : 0;
        8, 9: probe = $urandom_range(CP_MAX);
        default: probe = k;
      endcase
      if (probe > CP_MAX) probe = $urandom_range(CP_MAX);
      // Mostly the head of the list; sometimes a later, possibly misaligned,
      // word of it.
      if ($urandom_range(6) == 0) start = base + $urandom_range(2 * pairs - 1) + 1;
      else start = base + 1;
      send_request(lookup_row(START_W'(start), FIELD_W'(probe)));
    end
  endtask

  // Unstructured traffic: stray loads and lookups from anywhere, including
  // no list and starts beyond the table.
  task automatic run_noise();
    int start;
    case ($urandom_range(3))
      0: send_request(load_row(ADDR_W'($urandom), {$urandom, $urandom}));
      1: send_request(lookup_row(START_W'($urandom_range(TABLE_DEPTH, 1)),
                                 FIELD_W'($urandom_range(CP_MAX))));
      default: begin
        case ($urandom_range(3))
          0: start = 0;
          1: start = $urandom_range((1 << START_W) - 1, TABLE_DEPTH + 1);
          default: start = $urandom_range(TABLE_DEPTH, TABLE_DEPTH - 4);
        endcase
        send_request(lookup_row(START_W'(start), FIELD_W'($urandom_range(CP_MAX))));
      end
    endcase
  endtask

  // The four pacing regimes, visited twice over the random part.
  task automatic set_pacing(input int phase);
    case (phase)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
      default: begin send_idle_pct = 29; recv_stall_pct = 29; end
    endcase
  endtask

  always @(negedge clk_i) begin
    out_stall_r <= ($urandom_range(99) < recv_stall_pct);
  end

  // Scoreboard: every result taken from the block is matched against the
  // oldest lookup still waiting for its answer.
  always @(posedge clk_i) begin : score_results
    res_t got;
    res_t want;
    if (rst_n && out_valid_o && !out_stall_r) begin
      got = '{composed_code_point_o, found_o, range_error_o};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no lookup pending: cp %h found %b err %b",
                   $realtime, got.result_cp, got.found, got.range_error);
      end else begin
        want = pending_results.pop_front();
        if (got.result_cp !== want.result_cp || got.found !== want.found ||
            got.range_error !== want.range_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch: want cp %h found %b err %b, got cp %h found %b err %b",
                     $realtime, want.result_cp, want.found, want.range_error,
                     got.result_cp, got.found, got.range_error);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin : stimulus
    comp_req_t directed_rows[$];
    int        base_count;
    // Reset goes low at the start so that the block sees its falling edge.
    rst_n <= 1'b0;
    // No table reads at all, then starts beyond the table.
    directed_rows.push_back(typed_row(0, 0, 1'b0));
    directed_rows.push_back(typed_row(0, CP_MAX, 1'b0));
    directed_rows.push_back(typed_row(TABLE_DEPTH + 1, 5, 1'b1));
    directed_rows.push_back(typed_row((1 << START_W) - 1, CP_MAX, 1'b1));
    // A one-pair list at the bottom of the table, probed at each key.
    directed_rows.push_back(load_row(0, pack_lo('h10, KEY_MAX, 'h20, 1'b1)));
    directed_rows.push_back(load_row(1, pack_hi('h1, 'h30, 'hABCDE, 1'b1)));
    directed_rows.push_back(lookup_row(1, 0));
    directed_rows.push_back(lookup_row(1, 'h10));
    directed_rows.push_back(lookup_row(1, 'h18));
    directed_rows.push_back(lookup_row(1, 'h20));
    directed_rows.push_back(lookup_row(1, 'h30));
    directed_rows.push_back(lookup_row(1, 'h31));
    // A two-pair list: a match in the second pair, then the end of the list.
    directed_rows.push_back(load_row(2, pack_lo('h100, 'h111, 'h200, 1'b0)));
    directed_rows.push_back(load_row(3, pack_hi('h222, 'h300, 'h333, 1'b0)));
    directed_rows.push_back(load_row(4, pack_lo('h400, 'h444, 'h500, 1'b0)));
    directed_rows.push_back(load_row(5, pack_hi('h555, 'h600, 'h666, 1'b1)));
    directed_rows.push_back(lookup_row(3, 'h500));
    directed_rows.push_back(lookup_row(3, CP_MAX));
    // Against the top of the table: an unterminated pair walks off the end,
    // and a matching second key whose result word would lie past the end.
    directed_rows.push_back(load_row(TABLE_DEPTH - 2, pack_lo('h1, 'h2, 'h3, 1'b0)));
    directed_rows.push_back(load_row(TABLE_DEPTH - 1, pack_hi('h4, 'h5, 'h6, 1'b0)));
    directed_rows.push_back(typed_row(TABLE_DEPTH - 1, CP_MAX, 1'b1));
    directed_rows.push_back(load_row(TABLE_DEPTH - 1, pack_lo('h50, 'h77, 'h60, 1'b1)));
    directed_rows.push_back(typed_row(TABLE_DEPTH, 'h60, 1'b1));
    directed_rows.push_back(lookup_row(TABLE_DEPTH, 'h55));
    directed_rows.push_back(lookup_row(TABLE_DEPTH, 'h50));

    repeat (5) @(negedge clk_i);
    rst_n <= 1'b1;

    set_pacing(0);
    foreach (directed_rows[i]) send_request(directed_rows[i]);

    // Random part: mostly well-formed lists, the rest stray traffic.
    base_count = requests_sent;
    while (requests_sent - base_count < RANDOM_ITEMS) begin
      set_pacing(((requests_sent - base_count) * 8 / RANDOM_ITEMS) % 4);
      if ($urandom_range(9) < 7) run_list_episode();
      else run_noise();
    end

    in_valid_r     <= 1'b0;
    recv_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // Keep clocking after the last result so that a stray extra result would still be seen.
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/spcs_pkg.sv
design/spcs_ram.sv
design/spcs_walker.sv
design/sorted_pair_composition_search.sv
tb/tb_top.sv
